>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the emboss filter.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("emboss filter assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("emboss filter assertion failed");

`endif

>>> rtl/core/dgem_pkg.sv
// Package of the diagonal emboss filter: geometry limits, pixel types,
// register indexes and the line store control struct. Depends on nothing.
package dgem_pkg;

  localparam int CHANNELS     = 3;
  localparam int PIX_W        = 8;
  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 4096;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int DATA_W       = HEIGHT_REG_W;
  localparam int INDEX_W      = 1;
  localparam int MIN_DIM      = 3;
  localparam int EMBOSS_BIAS  = 128;
  localparam int PIX_MAX      = 255;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

  localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0]               chan_t;
  typedef logic [CHANNELS-1:0][PIX_W-1:0] pix_t;

  typedef struct packed {
    logic             accept;
    logic             restart;
    logic [COL_W-1:0] col;
  } ls_ctrl_t;

endpackage

>>> rtl/core/dgem_line_store.sv
// Line store of the previous row with its two-pixel delay of read values.
// Depends on dgem_pkg.
module dgem_line_store import dgem_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  ls_ctrl_t ctrl,
  input  pix_t     wr_pix,
  output pix_t     upper
);

  pix_t mem [MAX_WIDTH];
  pix_t upper_a;
  pix_t upper_b;

  // Read-before-write at the column of each transfer.
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      mem[ctrl.col] <= wr_pix;
      upper_a       <= mem[ctrl.col];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      upper_b <= '0;
    end else if (ctrl.accept) begin
      upper_b <= upper_a;
    end
  end

  assign upper = upper_b;

endmodule

>>> rtl/core/dgem_lane.sv
// One channel lane: upper pixel minus current pixel plus bias, saturated.
// Depends on dgem_pkg.
module dgem_lane import dgem_pkg::*; (
  input  chan_t upper,
  input  chan_t cur,
  output chan_t result
);

  localparam int SUM_W = PIX_W + 2;

  logic signed [SUM_W-1:0] sum;

  always_comb begin
    sum = $signed({2'b00, upper}) - $signed({2'b00, cur}) + SUM_W'(EMBOSS_BIAS);
    if (sum < 0) begin
      result = '0;
    end else if (sum > SUM_W'(PIX_MAX)) begin
      result = PIX_W'(PIX_MAX);
    end else begin
      result = sum[PIX_W-1:0];
    end
  end

endmodule

>>> rtl/core/diagonal_emboss_filter.sv
// Diagonal emboss filter over a raster stream of three-channel 8-bit pixels.
// It takes one pixel per clock and gives its result in the cycle after the
// transfer, from an output register, so a pixel enters every cycle while
// the result side keeps up; input stall follows a full, stalled output
// register. The previous row sits in a single-port line store that is read
// and written at the incoming column in the same cycle. Border pixels give
// no result. Writing either geometry register restarts the frame at row 0.
// Depends on dgem_pkg, dgem_line_store and dgem_lane.
module diagonal_emboss_filter import dgem_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                write_enable,
  input  logic [INDEX_W-1:0]  write_index,
  input  logic [DATA_W-1:0]   write_data,
  input  logic                pixel_valid,
  output logic                pixel_stall,
  input  logic [PIX_W-1:0]    pixel_ch0,
  input  logic [PIX_W-1:0]    pixel_ch1,
  input  logic [PIX_W-1:0]    pixel_ch2,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [PIX_W-1:0]    out_ch0,
  output logic [PIX_W-1:0]    out_ch1,
  output logic [PIX_W-1:0]    out_ch2,
  output logic [ROW_W-1:0]    out_row,
  output logic [COL_W-1:0]    out_col,
  output logic                frame_end
);

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [ROW_W-1:0]        row_count;
  logic [COL_W-1:0]        col_count;
  logic [WIDTH_REG_W-1:0]  width_eff;
  logic [HEIGHT_REG_W-1:0] height_eff;
  logic [WIDTH_REG_W-1:0]  width_last;
  logic [HEIGHT_REG_W-1:0] height_last;
  logic                    col_last;
  logic                    row_last;
  logic                    emit;
  logic                    accept;
  logic                    out_load;
  ls_ctrl_t                ls_ctrl;
  pix_t                    cur_pix;
  pix_t                    upper_pix;
  pix_t                    lane_pix;
  pix_t                    out_pix;

  always_comb begin
    if (image_width < WIDTH_REG_W'(MIN_DIM)) begin
      width_eff = WIDTH_REG_W'(MIN_DIM);
    end else if (image_width > WIDTH_REG_W'(MAX_WIDTH)) begin
      width_eff = WIDTH_REG_W'(MAX_WIDTH);
    end else begin
      width_eff = image_width;
    end
    if (image_height < HEIGHT_REG_W'(MIN_DIM)) begin
      height_eff = HEIGHT_REG_W'(MIN_DIM);
    end else if (image_height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      height_eff = HEIGHT_REG_W'(MAX_HEIGHT);
    end else begin
      height_eff = image_height;
    end
  end

  assign width_last  = width_eff - 1'b1;
  assign height_last = height_eff - 1'b1;
  assign col_last    = {1'b0, col_count} >= width_last;
  assign row_last    = {1'b0, row_count} >= height_last;
  assign emit        = (row_count >= ROW_W'(2)) && (col_count >= COL_W'(2));

  assign out_load    = !result_valid || !result_stall;
  assign pixel_stall = !out_load;
  assign accept      = pixel_valid && out_load;

  assign cur_pix = {pixel_ch2, pixel_ch1, pixel_ch0};

  always_comb begin
    ls_ctrl.accept  = accept;
    ls_ctrl.restart = write_enable;
    ls_ctrl.col     = col_count;
  end

  dgem_line_store u_line_store (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ls_ctrl),
    .wr_pix (cur_pix),
    .upper  (upper_pix)
  );

  for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
    dgem_lane u_lane (
      .upper  (upper_pix[k]),
      .cur    (cur_pix[k]),
      .result (lane_pix[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      row_count    <= '0;
      col_count    <= '0;
    end else if (write_enable) begin
      if (write_index == REG_IMAGE_WIDTH) begin
        image_width <= write_data[WIDTH_REG_W-1:0];
      end else begin
        image_height <= write_data[HEIGHT_REG_W-1:0];
      end
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (col_last) begin
        col_count <= '0;
        row_count <= row_last ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= accept && emit;
    end
  end

  // Merge the lane results with the position of the output pixel.
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_pix   <= lane_pix;
      out_row   <= row_count - 1'b1;
      out_col   <= col_count - 1'b1;
      frame_end <= ({1'b0, row_count} == height_last) && ({1'b0, col_count} == width_last);
    end
  end

  assign out_ch0 = out_pix[0];
  assign out_ch1 = out_pix[1];
  assign out_ch2 = out_pix[2];

endmodule

>>> rtl/core/dgem_checker.sv
// Port-level checker of the diagonal emboss filter, bound to the top level.
// Depends on dgem_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dgem_checker import dgem_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             pixel_stall,
  input logic             result_valid,
  input logic             result_stall,
  input logic [PIX_W-1:0] out_ch0,
  input logic [ROW_W-1:0] out_row,
  input logic [COL_W-1:0] out_col
);

  `ASSERT_NEXT(a_out_hold, clk, rst, result_valid && result_stall, result_valid && $stable(out_ch0) && $stable(out_row) && $stable(out_col))
  `ASSERT_SAME(a_stall_cause, clk, rst, pixel_stall, result_valid && result_stall)
  `ASSERT_SAME(a_no_border, clk, rst, result_valid, (out_row != '0) && (out_col != '0))

endmodule

bind diagonal_emboss_filter dgem_checker u_checker (.*);

>>> dv/diagonal_emboss_filter_test.sv
// Self-checking testbench for diagonal_emboss_filter: a scoreboard class predicts each
// embossed pixel from the accepted input stream, and plain tasks drive pixels and geometry.
// Depends on dgem_pkg and the diagonal_emboss_filter RTL.
`timescale 1ns / 100ps

module diagonal_emboss_filter_test;
  import dgem_pkg::*;

  typedef struct packed {
    pix_t                  chans;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
    logic                  last;
  } emboss_result_t;

  class emboss_tracker;
    pix_t                    line_store [MAX_WIDTH];
    pix_t                    upper_a;
    pix_t                    upper_b;
    int unsigned             row_pos;
    int unsigned             col_pos;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    emboss_result_t          expected_pixels [$];
    int unsigned             errors;

    function new();
      foreach (line_store[i]) line_store[i] = '0;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      errors = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      upper_a = '0;
      upper_b = '0;
      row_pos = 0;
      col_pos = 0;
    endfunction

    function void write_reg(logic [INDEX_W-1:0] index, logic [DATA_W-1:0] value);
      case (index)
        REG_IMAGE_WIDTH: begin
          width_reg = value[WIDTH_REG_W-1:0];
          restart_frame();
        end
        REG_IMAGE_HEIGHT: begin
          height_reg = value[HEIGHT_REG_W-1:0];
          restart_frame();
        end
        default: ;
      endcase
    endfunction

    function int unsigned active_width();
      if (width_reg < MIN_DIM) return MIN_DIM;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned active_height();
      if (height_reg < MIN_DIM) return MIN_DIM;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    function chan_t emboss_channel(chan_t upper, chan_t current);
      int v;
      v = int'(upper) - int'(current) + EMBOSS_BIAS;
      if (v < 0) v = 0;
      else if (v > PIX_MAX) v = PIX_MAX;
      return chan_t'(v);
    endfunction

    function void take_pixel(pix_t px);
      int unsigned    w;
      int unsigned    h;
      int unsigned    idx;
      emboss_result_t res;
      w = active_width();
      h = active_height();
      if (row_pos >= 2 && col_pos >= 2 && row_pos < h && col_pos < w) begin
        for (int k = 0; k < CHANNELS; k++) res.chans[k] = emboss_channel(upper_b[k], px[k]);
        res.row = ROW_W'(row_pos - 1);
        res.col = COL_W'(col_pos - 1);
        res.last = (row_pos == h - 1 && col_pos == w - 1);
        expected_pixels.push_back(res);
      end
      idx = (col_pos < MAX_WIDTH) ? col_pos : 0;
      upper_b = upper_a;
      upper_a = line_store[idx];
      line_store[idx] = px;
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
        col_pos = col_pos + 1;
      end
    endfunction

    function void check_result(emboss_result_t got);
      emboss_result_t want;
      if (expected_pixels.size() == 0) begin
        $error("result transfer at row %0d column %0d with no pixel awaiting it",
               got.row, got.col);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      for (int k = 0; k < CHANNELS; k++) begin
        if (got.chans[k] !== want.chans[k]) begin
          $error("out_ch%0d: expected %0d, actual %0d", k, want.chans[k], got.chans[k]);
          errors++;
        end
      end
      if (got.row !== want.row) begin
        $error("out_row: expected %0d, actual %0d", want.row, got.row);
        errors++;
      end
      if (got.col !== want.col) begin
        $error("out_col: expected %0d, actual %0d", want.col, got.col);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("frame_end: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_pixels.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               write_enable = 1'b0;
  logic [INDEX_W-1:0] write_index = '0;
  logic [DATA_W-1:0]  write_data = '0;
  logic               pixel_valid = 1'b0;
  logic               pixel_stall;
  logic [PIX_W-1:0]   pixel_ch0 = '0;
  logic [PIX_W-1:0]   pixel_ch1 = '0;
  logic [PIX_W-1:0]   pixel_ch2 = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [PIX_W-1:0]   out_ch0;
  logic [PIX_W-1:0]   out_ch1;
  logic [PIX_W-1:0]   out_ch2;
  logic [ROW_W-1:0]   out_row;
  logic [COL_W-1:0]   out_col;
  logic               frame_end;

  emboss_tracker tracker = new();
  int unsigned   send_idle_max = 0;
  int unsigned   take_idle_max = 0;
  int unsigned   hold_request = 0;

  diagonal_emboss_filter dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_ch0    (pixel_ch0),
    .pixel_ch1    (pixel_ch1),
    .pixel_ch2    (pixel_ch2),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_ch0      (out_ch0),
    .out_ch1      (out_ch1),
    .out_ch2      (out_ch2),
    .out_row      (out_row),
    .out_col      (out_col),
    .frame_end    (frame_end)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid === 1'b1 && result_stall === 1'b0)
        tracker.check_result({out_ch2, out_ch1, out_ch0, out_row, out_col, frame_end});
      if (pixel_valid === 1'b1 && pixel_stall === 1'b0)
        tracker.take_pixel({pixel_ch2, pixel_ch1, pixel_ch0});
    end
  end

  function automatic pix_t random_pixel();
    pix_t p;
    p = pix_t'($urandom);
    if ($urandom_range(0, 3) == 0) p[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return p;
  endfunction

  task automatic send_pixel(input pix_t px);
    int unsigned gap;
    gap = $urandom_range(0, send_idle_max);
    if (gap != 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_ch0 <= px[0];
    pixel_ch1 <= px[1];
    pixel_ch2 <= px[2];
    do @(posedge clk); while (pixel_stall !== 1'b0);
  endtask

  task automatic drain_results();
    pixel_valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] index, input int unsigned value);
    write_enable <= 1'b1;
    write_index <= index;
    write_data <= DATA_W'(value);
    @(posedge clk);
    tracker.write_reg(index, DATA_W'(value));
    write_enable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_small_frame(input pix_t upper, input pix_t current);
    for (int i = 0; i < 9; i++)
      send_pixel(i == 3 ? upper : (i == 8 ? current : random_pixel()));
  endtask

  initial begin : take_results
    int unsigned stall_cycles;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_request != 0) begin
        stall_cycles = hold_request;
        hold_request = 0;
      end else begin
        stall_cycles = $urandom_range(0, take_idle_max);
      end
      if (stall_cycles != 0) begin
        result_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
        result_stall <= 1'b0;
      end
      do @(posedge clk); while (result_valid !== 1'b1);
    end
  end

  initial begin : stimulus
    int unsigned w_val;
    int unsigned h_val;
    int unsigned which;
    int unsigned frame;
    int unsigned n;
    int unsigned done_items;
    int unsigned phase;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default geometry straight out of reset.
    for (int i = 0; i < 2 * 640 + 6; i++) send_pixel(random_pixel());
    drain_results();

    // Below-minimum geometry clamps to 3x3; saturation at both ends and exact limits.
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 0);
    send_small_frame({8'd127, 8'd0, 8'd255}, {8'd0, 8'd255, 8'd0});
    send_small_frame({8'd255, 8'd100, 8'd0}, {8'd255, 8'd50, 8'd128});
    drain_results();

    done_items = 0;
    phase = 0;
    while (done_items < 300) begin
      w_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) :
              (($urandom_range(0, 5) == 0) ? $urandom_range(13, 24) : $urandom_range(3, 12));
      h_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) :
              (($urandom_range(0, 5) == 0) ? $urandom_range(9, 12) : $urandom_range(3, 8));
      which = $urandom_range(0, 2);
      send_idle_max = $urandom_range(0, 1) ? 18 : 0;
      take_idle_max = $urandom_range(0, 1) ? 18 : 0;
      if (phase == 0) begin
        w_val = 5;
        h_val = 6;
        which = 0;
        send_idle_max = 0;
      end
      if (which != 2) write_reg(REG_IMAGE_WIDTH, w_val);
      if (which != 1) write_reg(REG_IMAGE_HEIGHT, h_val);
      frame = tracker.active_width() * tracker.active_height();
      n = (phase == 0) ? 60 : $urandom_range(frame / 2, 2 * frame + tracker.active_width());
      for (int i = 0; i < n; i++) begin
        if (phase == 0 && i == n / 2) hold_request = 150;
        if (phase == 1 && i == n / 2) drain_results();
        send_pixel(random_pixel());
      end
      done_items += n;
      drain_results();
      phase++;
    end

    repeat (10) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
